### hdl/sfm_pkg.sv
`default_nettype none
package sfm_pkg;

  localparam int THRESH_W   = 4;
  localparam int BEAM_IDX_W = 4;
  localparam int ANT_IDX_W  = 4;
  localparam int MASK_W     = 16;
  localparam int MAX_OUT    = 16;
  localparam int TENTHS     = 10;

  localparam logic [THRESH_W-1:0] THRESH_RST = 4'd5;

endpackage
`default_nettype wire

### hdl/sfm_ram.sv
`default_nettype none
module sfm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 512
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/status_fraction_monitor_unit.sv
`default_nettype none
// Status fraction monitor.
// Input channel (in_valid/in_ready): one beat is either a status sample
// (req_type 0) for one channel/beam/antenna entry, or a report request
// (req_type 1) for one channel. Output channel (out_valid/out_ready) carries
// report results: one per beam in full mode, one OR-of-all-beams in summary
// mode; last marks the final beat of a report. Samples produce no output.
// Config channel (cfg_valid/cfg_ready) writes alarm_tenths; always ready.
// From the accept cycle until in_ready rises again, a sample steps through
// accept, RAM read and saturating write back. A report walks the channel's
// entries (first min(NA,16) antennas per beam) through the counter RAM (one
// read, one write port), an address step and a registered read + compare
// per entry, an output step per result: NB_OUT results in full mode, one for
// all NUM_BEAMS beams in summary mode. in_ready is low for the whole item.
// A stalled output register holds the sequencer before each result until the
// previous one is taken. Reset (and a report with clear_after) runs a clearing
// pass over all NUM_CHANNELS*NUM_BEAMS*NUM_ANTENNAS entries, one per cycle,
// before in_ready rises again; alarm_tenths resets to 5.
module status_fraction_monitor_unit #(
  parameter int NUM_CHANNELS = 2,
  parameter int NUM_BEAMS    = 16,
  parameter int NUM_ANTENNAS = 16,
  parameter int COUNT_WIDTH  = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sfm_pkg::THRESH_W-1:0]     alarm_tenths,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             req_type,
  input  wire logic                             channel,
  input  wire logic [sfm_pkg::BEAM_IDX_W-1:0]   beam,
  input  wire logic [sfm_pkg::ANT_IDX_W-1:0]    antenna,
  input  wire logic                             agc_flag,
  input  wire logic                             lopwr_flag,
  input  wire logic                             full_report,
  input  wire logic                             clear_after,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [sfm_pkg::BEAM_IDX_W-1:0]        beam_index,
  output logic [sfm_pkg::MASK_W-1:0]            agc_mask,
  output logic [sfm_pkg::MASK_W-1:0]            lopwr_mask,
  output logic                                  last
);

  import sfm_pkg::*;

  localparam int CW      = COUNT_WIDTH;
  localparam int PW      = CW + 4;
  localparam int DEPTH   = NUM_CHANNELS * NUM_BEAMS * NUM_ANTENNAS;
  localparam int ADDR_W  = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int ENTRY_W = 3 * CW;
  localparam int BA      = NUM_BEAMS * NUM_ANTENNAS;
  localparam int NB_OUT  = NUM_BEAMS < MAX_OUT ? NUM_BEAMS : MAX_OUT;
  localparam int ANT_LIM = NUM_ANTENNAS < MASK_W ? NUM_ANTENNAS : MASK_W;
  localparam int BEAM_W  = NUM_BEAMS > 1 ? $clog2(NUM_BEAMS) : 1;
  localparam int ANT_W   = ANT_LIM > 1 ? $clog2(ANT_LIM) : 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SRD   = 3'd2;
  localparam logic [2:0] S_SWR   = 3'd3;
  localparam logic [2:0] S_RRD   = 3'd4;
  localparam logic [2:0] S_REVAL = 3'd5;
  localparam logic [2:0] S_ROUT  = 3'd6;

  logic [2:0]           state;
  logic [THRESH_W-1:0]  thresh;
  logic [ADDR_W-1:0]    clr_addr;
  logic                 lat_ch;
  logic                 lat_chok;
  logic [BEAM_IDX_W-1:0] lat_beam;
  logic [ANT_IDX_W-1:0] lat_ant;
  logic                 lat_agc;
  logic                 lat_lop;
  logic                 lat_full;
  logic                 lat_clr;
  logic [BEAM_W-1:0]    bcnt;
  logic [ANT_W-1:0]     acnt;
  logic [MASK_W-1:0]    agc_acc;
  logic [MASK_W-1:0]    lop_acc;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic [31:0]          smp_addr_full;
  logic [31:0]          rep_addr_full;
  logic [CW-1:0]        q_agc;
  logic [CW-1:0]        q_lop;
  logic [CW-1:0]        q_cnt;
  logic [CW-1:0]        n_agc;
  logic [CW-1:0]        n_lop;
  logic [CW-1:0]        n_cnt;
  logic [PW-1:0]        agc10;
  logic [PW-1:0]        lop10;
  logic [PW-1:0]        thr_cnt;
  logic                 hit_agc;
  logic                 hit_lop;
  logic [MASK_W-1:0]    bit_sel;
  logic                 beam_end;
  logic                 last_res;
  logic                 out_load;
  logic                 smp_ok;
  logic                 ch_ok;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  assign ch_ok  = 32'(channel) < NUM_CHANNELS;
  assign smp_ok = ch_ok && (32'(beam) < NUM_BEAMS) && (32'(antenna) < NUM_ANTENNAS);

  assign smp_addr_full = 32'(lat_ch) * 32'(BA) + 32'(lat_beam) * 32'(NUM_ANTENNAS)
                       + 32'(lat_ant);
  assign rep_addr_full = (lat_chok ? 32'(lat_ch) : 32'd0) * 32'(BA)
                       + 32'(bcnt) * 32'(NUM_ANTENNAS) + 32'(acnt);

  assign {q_agc, q_lop, q_cnt} = ram_rdata;

  assign n_agc = (q_agc == {CW{1'b1}}) ? q_agc : q_agc + CW'(lat_agc);
  assign n_lop = (q_lop == {CW{1'b1}}) ? q_lop : q_lop + CW'(lat_lop);
  assign n_cnt = (q_cnt == {CW{1'b1}}) ? q_cnt : q_cnt + CW'(1);

  // threshold compare: 10*sum > thresh*count
  assign agc10   = PW'(q_agc) * PW'(TENTHS);
  assign lop10   = PW'(q_lop) * PW'(TENTHS);
  assign thr_cnt = PW'(q_cnt) * PW'(thresh);
  assign hit_agc = lat_chok && (agc10 > thr_cnt);
  assign hit_lop = lat_chok && (lop10 > thr_cnt);

  always_comb begin
    for (int i = 0; i < MASK_W; i++) begin
      bit_sel[i] = (32'(acnt) == i);
    end
  end

  assign beam_end = (acnt == ANT_W'(ANT_LIM - 1));
  assign last_res = lat_full ? (bcnt == BEAM_W'(NB_OUT - 1)) : 1'b1;
  assign out_load = (state == S_ROUT) && (!out_valid || out_ready);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = smp_addr_full[ADDR_W-1:0];
    ram_wdata = {n_agc, n_lop, n_cnt};
    ram_raddr = rep_addr_full[ADDR_W-1:0];
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_SRD: begin
        ram_raddr = smp_addr_full[ADDR_W-1:0];
      end
      S_SWR: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  sfm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= THRESH_RST;
    end else if (cfg_valid) begin
      thresh <= alarm_tenths;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
          clr_addr <= clr_addr + ADDR_W'(1);
        end
        S_IDLE: begin
          if (in_valid) begin
            lat_ch   <= channel;
            lat_chok <= ch_ok;
            lat_beam <= beam;
            lat_ant  <= antenna;
            lat_agc  <= agc_flag;
            lat_lop  <= lopwr_flag;
            lat_full <= full_report;
            lat_clr  <= clear_after;
            bcnt     <= '0;
            acnt     <= '0;
            agc_acc  <= '0;
            lop_acc  <= '0;
            if (req_type) begin
              state <= S_RRD;
            end else if (smp_ok) begin
              state <= S_SRD;
            end
          end
        end
        S_SRD: begin
          state <= S_SWR;
        end
        S_SWR: begin
          state <= S_IDLE;
        end
        S_RRD: begin
          state <= S_REVAL;
        end
        S_REVAL: begin
          agc_acc <= agc_acc | (hit_agc ? bit_sel : '0);
          lop_acc <= lop_acc | (hit_lop ? bit_sel : '0);
          if (!beam_end) begin
            acnt  <= acnt + ANT_W'(1);
            state <= S_RRD;
          end else if (lat_full || bcnt == BEAM_W'(NUM_BEAMS - 1)) begin
            state <= S_ROUT;
          end else begin
            acnt  <= '0;
            bcnt  <= bcnt + BEAM_W'(1);
            state <= S_RRD;
          end
        end
        S_ROUT: begin
          if (out_load) begin
            out_valid  <= 1'b1;
            beam_index <= lat_full ? BEAM_IDX_W'(bcnt) : '0;
            agc_mask   <= agc_acc;
            lopwr_mask <= lop_acc;
            last       <= last_res;
            if (last_res) begin
              clr_addr <= '0;
              state    <= lat_clr ? S_CLEAR : S_IDLE;
            end else begin
              bcnt    <= bcnt + BEAM_W'(1);
              acnt    <= '0;
              agc_acc <= '0;
              lop_acc <= '0;
              state   <= S_RRD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_reset_blocks_input: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input accepted right after reset");

  a_sample_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWR) |=> (state == S_IDLE))
    else $error("sample write back did not return to idle");

  a_summary_accumulates: assert property (@(posedge clk) disable iff (rst)
    (state == S_REVAL && !lat_full) |=> ((agc_acc & $past(agc_acc)) == $past(agc_acc)))
    else $error("summary mask lost a bit");

  a_clear_follows: assert property (@(posedge clk) disable iff (rst)
    (out_load && last_res && lat_clr) |=> (state == S_CLEAR && clr_addr == '0))
    else $error("clear pass did not start after report");

endmodule
`default_nettype wire

### test/tb_top.sv
`default_nettype none
module tb_top;
  import sfm_pkg::*;

  localparam int CHANNELS = 2;
  localparam int BEAMS = 16;
  localparam int ANTENNAS = 16;
  localparam int CYCLE_LIMIT = 2_000_000;
  // covers the reset / clear_after sweep over CHANNELS*BEAMS*ANTENNAS entries, plus margin
  localparam int SETTLE_CYCLES = 600;
  localparam int PHASE_ITEMS = 70;
  localparam int HOT_ENTRIES = 6;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  typedef struct packed {
    logic req;
    logic ch;
    logic [BEAM_IDX_W-1:0] bm;
    logic [ANT_IDX_W-1:0] ant;
    logic agc;
    logic lop;
    logic full;
    logic clr;
    logic drain;
  } status_req_t;

  typedef struct packed {
    logic [BEAM_IDX_W-1:0] beam_index;
    logic [MASK_W-1:0] agc_mask;
    logic [MASK_W-1:0] lopwr_mask;
    logic last;
  } mask_beat_t;

  typedef enum logic [1:0] {READY_ALWAYS, READY_RANDOM, READY_ONE_IN_FOUR} ready_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [THRESH_W-1:0] alarm_tenths = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = 1'b0;
  logic channel = 1'b0;
  logic [BEAM_IDX_W-1:0] beam = '0;
  logic [ANT_IDX_W-1:0] antenna = '0;
  logic agc_flag = 1'b0;
  logic lopwr_flag = 1'b0;
  logic full_report = 1'b0;
  logic clear_after = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [BEAM_IDX_W-1:0] beam_index;
  logic [MASK_W-1:0] agc_mask;
  logic [MASK_W-1:0] lopwr_mask;
  logic last;

  status_fraction_monitor_unit #(
    .NUM_CHANNELS(CHANNELS),
    .NUM_BEAMS(BEAMS),
    .NUM_ANTENNAS(ANTENNAS),
    .COUNT_WIDTH(16)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .alarm_tenths(alarm_tenths),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .channel(channel),
    .beam(beam),
    .antenna(antenna),
    .agc_flag(agc_flag),
    .lopwr_flag(lopwr_flag),
    .full_report(full_report),
    .clear_after(clear_after),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .beam_index(beam_index),
    .agc_mask(agc_mask),
    .lopwr_mask(lopwr_mask),
    .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  status_req_t pending_reqs[$];
  mask_beat_t due_reports[$];

  logic [15:0] agc_tally [CHANNELS][BEAMS][ANTENNAS];
  logic [15:0] lopwr_tally [CHANNELS][BEAMS][ANTENNAS];
  logic [15:0] sample_tally [CHANNELS][BEAMS][ANTENNAS];
  logic [THRESH_W-1:0] thresh_shadow = THRESH_RST;

  int mismatches = 0;
  int cycles = 0;

  function automatic logic [15:0] sat_bump(input logic [15:0] v, input logic inc);
    return (v == 16'hFFFF) ? v : v + 16'(inc);
  endfunction

  function automatic logic over_threshold(input logic [15:0] sum, input logic [15:0] n);
    return (32'(sum) * TENTHS) > (32'(thresh_shadow) * 32'(n));
  endfunction

  function automatic void clear_tallies();
    foreach (sample_tally[c, b, a]) begin
      agc_tally[c][b][a] = '0;
      lopwr_tally[c][b][a] = '0;
      sample_tally[c][b][a] = '0;
    end
  endfunction

  function automatic void beam_masks(input int ch, input int b,
                                     output logic [MASK_W-1:0] am,
                                     output logic [MASK_W-1:0] lm);
    am = '0;
    lm = '0;
    for (int a = 0; a < ANTENNAS && a < MASK_W; a++) begin
      am[a] = over_threshold(agc_tally[ch][b][a], sample_tally[ch][b][a]);
      lm[a] = over_threshold(lopwr_tally[ch][b][a], sample_tally[ch][b][a]);
    end
  endfunction

  // apply one accepted beat to the tallies, queue the masks it produces
  task automatic apply_status(input status_req_t r);
    mask_beat_t beat;
    logic [MASK_W-1:0] am, lm;
    int nb;
    if (r.req == REQ_SAMPLE) begin
      agc_tally[r.ch][r.bm][r.ant] = sat_bump(agc_tally[r.ch][r.bm][r.ant], r.agc);
      lopwr_tally[r.ch][r.bm][r.ant] = sat_bump(lopwr_tally[r.ch][r.bm][r.ant], r.lop);
      sample_tally[r.ch][r.bm][r.ant] = sat_bump(sample_tally[r.ch][r.bm][r.ant], 1'b1);
    end else begin
      if (r.full) begin
        nb = (BEAMS < MAX_OUT) ? BEAMS : MAX_OUT;
        for (int b = 0; b < nb; b++) begin
          beam_masks(r.ch, b, am, lm);
          beat.beam_index = BEAM_IDX_W'(b);
          beat.agc_mask = am;
          beat.lopwr_mask = lm;
          beat.last = (b == nb - 1);
          due_reports.push_back(beat);
        end
      end else begin
        beat = '0;
        for (int b = 0; b < BEAMS; b++) begin
          beam_masks(r.ch, b, am, lm);
          beat.agc_mask |= am;
          beat.lopwr_mask |= lm;
        end
        beat.last = 1'b1;
        due_reports.push_back(beat);
      end
      if (r.clr) clear_tallies();
    end
  endtask

  // driver: bursts of beats with random gaps; drain-marked beats wait for
  // every due result before going out
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : driver
    status_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      clear_tallies();
    end else begin
      if (in_valid && in_ready) apply_status(pending_reqs.pop_front());
      if (!(in_valid && !in_ready)) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain && due_reports.size() != 0)) begin
          nxt = pending_reqs[0];
          in_valid <= 1'b1;
          req_type <= nxt.req;
          channel <= nxt.ch;
          beam <= nxt.bm;
          antenna <= nxt.ant;
          agc_flag <= nxt.agc;
          lopwr_flag <= nxt.lop;
          full_report <= nxt.full;
          clear_after <= nxt.clr;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20)
                                                     : $urandom_range(12, 1);
            gap_left = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 10)
                                                   : $urandom_range(6, 1);
          end else begin
            burst_left = burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic flag_beat(input string why, input mask_beat_t want, input mask_beat_t got);
    if (mismatches < 10)
      $display("mismatch (%0s): want beam %0d agc %h lopwr %h last %b, got beam %0d agc %h lopwr %h last %b",
               why, want.beam_index, want.agc_mask, want.lopwr_mask, want.last,
               got.beam_index, got.agc_mask, got.lopwr_mask, got.last);
    mismatches++;
  endtask

  ready_mode_t stall_mode = READY_ALWAYS;
  int mode_left = 0;
  logic [1:0] stall_phase = '0;

  always @(posedge clk) begin : monitor
    mask_beat_t got;
    mask_beat_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {beam_index, agc_mask, lopwr_mask, last};
        if (due_reports.size() == 0) begin
          flag_beat("no beat due", '0, got);
        end else begin
          want = due_reports.pop_front();
          if (got !== want) flag_beat("field", want, got);
        end
      end
      if (mode_left == 0) begin
        stall_mode = ready_mode_t'($urandom_range(2, 0));
        mode_left = $urandom_range(300, 40);
      end else begin
        mode_left = mode_left - 1;
      end
      stall_phase <= stall_phase + 2'd1;
      case (stall_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_RANDOM: out_ready <= ($urandom_range(9, 0) < 6);
        default: out_ready <= (stall_phase == 2'd0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status_fraction_monitor_unit verification failed");
      $finish;
    end
  end

  task automatic queue_status(input logic req, input logic ch, input int bm, input int ant,
                              input logic agc, input logic lop, input logic full,
                              input logic clr);
    status_req_t r;
    r = '{req, ch, BEAM_IDX_W'(bm), ANT_IDX_W'(ant), agc, lop, full, clr, 1'b0};
    pending_reqs.push_back(r);
  endtask

  task automatic settle();
    while (pending_reqs.size() != 0 || in_valid || due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_thresh(input logic [THRESH_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    alarm_tenths <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    thresh_shadow = v;
    cfg_valid <= 1'b0;
  endtask

  // samples mostly land on a few hot entries, each with its own alarm odds,
  // so fractions straddle the threshold
  task automatic build_phase(input int n);
    logic hot_ch [HOT_ENTRIES];
    int hot_bm [HOT_ENTRIES];
    int hot_ant [HOT_ENTRIES];
    int hot_agc [HOT_ENTRIES];
    int hot_lop [HOT_ENTRIES];
    status_req_t r;
    int h;
    int roll;
    for (int i = 0; i < HOT_ENTRIES; i++) begin
      hot_ch[i] = 1'($urandom);
      hot_bm[i] = $urandom_range(BEAMS - 1, 0);
      hot_ant[i] = $urandom_range(ANTENNAS - 1, 0);
      hot_agc[i] = $urandom_range(100, 0);
      hot_lop[i] = $urandom_range(100, 0);
    end
    for (int k = 0; k < n; k++) begin
      r = status_req_t'($bits(status_req_t)'($urandom));
      roll = $urandom_range(99, 0);
      if (roll < 10) begin
        r.req = REQ_REPORT;
        r.full = ($urandom_range(9, 0) < 6);
        r.clr = ($urandom_range(99, 0) < 15);
      end else begin
        r.req = REQ_SAMPLE;
        if (roll < 78) begin
          h = $urandom_range(HOT_ENTRIES - 1, 0);
          r.ch = hot_ch[h];
          r.bm = BEAM_IDX_W'(hot_bm[h]);
          r.ant = ANT_IDX_W'(hot_ant[h]);
          r.agc = ($urandom_range(99, 0) < hot_agc[h]);
          r.lop = ($urandom_range(99, 0) < hot_lop[h]);
        end
      end
      r.drain = (k == n / 2) || ($urandom_range(99, 0) < 3);
      pending_reqs.push_back(r);
    end
  endtask

  initial begin
    logic [THRESH_W-1:0] th;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset threshold: empty report, ties at exactly half, both channels,
    // corner beams/antennas, clear after report, ignored fields on samples
    queue_status(REQ_REPORT, 1'b0, 0, 0, 1'b0, 1'b0, 1'b1, 1'b0);
    queue_status(REQ_SAMPLE, 1'b0, 0, 0, 1'b1, 1'b0, 1'b1, 1'b1);
    queue_status(REQ_SAMPLE, 1'b0, 0, 0, 1'b0, 1'b1, 1'b0, 1'b0);
    queue_status(REQ_SAMPLE, 1'b1, 15, 15, 1'b1, 1'b1, 1'b0, 1'b1);
    queue_status(REQ_SAMPLE, 1'b1, 15, 0, 1'b1, 1'b0, 1'b1, 1'b0);
    queue_status(REQ_SAMPLE, 1'b0, 7, 15, 1'b0, 1'b1, 1'b0, 1'b0);
    queue_status(REQ_REPORT, 1'b0, 15, 15, 1'b1, 1'b1, 1'b0, 1'b0);
    queue_status(REQ_REPORT, 1'b1, 0, 0, 1'b0, 1'b0, 1'b1, 1'b0);
    queue_status(REQ_SAMPLE, 1'b0, 0, 0, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_status(REQ_REPORT, 1'b0, 0, 0, 1'b0, 1'b0, 1'b1, 1'b1);
    queue_status(REQ_REPORT, 1'b1, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_status(REQ_SAMPLE, 1'b1, 3, 9, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_status(REQ_SAMPLE, 1'b1, 10, 5, 1'b1, 1'b1, 1'b1, 1'b1);
    queue_status(REQ_REPORT, 1'b1, 0, 0, 1'b0, 1'b0, 1'b0, 1'b1);
    pending_reqs[pending_reqs.size() - 1].drain = 1'b1;
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: th = 4'd10;
        1: th = 4'd0;
        2: th = 4'd15;
        3: th = 4'd1;
        4: th = 4'd9;
        default: th = THRESH_W'($urandom_range(8, 2));
      endcase
      write_thresh(th);
      build_phase(PHASE_ITEMS);
      settle();
    end

    if (mismatches == 0 && due_reports.size() == 0) begin
      $display("status_fraction_monitor_unit verification clean");
    end else begin
      $display("status_fraction_monitor_unit verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
hdl/sfm_pkg.sv
hdl/sfm_ram.sv
hdl/status_fraction_monitor_unit.sv
test/tb_top.sv
